// ----- rtl/adjustable_window_moving_average_macros.svh -----
// assertion macros for the adjustable window moving average block
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef ADJUSTABLE_WINDOW_MOVING_AVERAGE_MACROS_SVH
`define ADJUSTABLE_WINDOW_MOVING_AVERAGE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define AWMA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AWMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/awma_pkg.sv -----
// shared constants and types for the adjustable window moving average
// no dependencies
`default_nettype none

package awma_pkg;

  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int SAMPLE_BITS_DEF   = 16;

  localparam int AVG_BITS = 16;
  localparam int WIN_BITS = 4;

  localparam logic [7:0] CMD_WIDEN  = 8'h55;  // 'U'
  localparam logic [7:0] CMD_NARROW = 8'h44;  // 'D'

  // operation select for the shared add/subtract unit
  typedef struct packed {
    logic clear;
    logic add;
    logic div_step;
  } alu_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/awma_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module awma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/awma_alu.sv -----
// shared adder/subtractor: accumulates the window sum, then runs a
// restoring division one quotient bit per cycle; uses awma_pkg
`default_nettype none

module awma_alu #(
  parameter int SAMPLE_BITS = 16,
  parameter int NB          = 4,
  parameter int SUMW        = 20
) (
  input  wire logic                   clk_i,
  input  wire awma_pkg::alu_ctrl_t    ctrl_i,
  input  wire logic [SAMPLE_BITS-1:0] addend_i,
  input  wire logic [NB-1:0]          divisor_i,
  output logic      [SUMW-1:0]        acc_o
);

  import awma_pkg::*;

  logic [SUMW-1:0] acc_q, acc_d;
  logic [NB-1:0]   rem_q, rem_d;
  logic [NB:0]     shifted;
  logic [SUMW:0]   op_a, op_b, res;
  logic            sub;
  logic            neg;

  assign shifted = {rem_q, acc_q[SUMW-1]};

  // single adder, operands picked by the current operation
  always_comb begin
    if (ctrl_i.div_step) begin
      op_a = (SUMW+1)'(shifted);
      op_b = (SUMW+1)'(divisor_i);
      sub  = 1'b1;
    end else begin
      op_a = {1'b0, acc_q};
      op_b = (SUMW+1)'(addend_i);
      sub  = 1'b0;
    end
    res = op_a + (sub ? ~op_b : op_b) + (SUMW+1)'(sub);
    neg = res[SUMW];
  end

  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
      rem_d = '0;
    end else if (ctrl_i.add) begin
      acc_d = res[SUMW-1:0];
    end else if (ctrl_i.div_step) begin
      // quotient bits shift in from the bottom as dividend bits leave the top
      acc_d = {acc_q[SUMW-2:0], ~neg};
      rem_d = neg ? shifted[NB-1:0] : res[NB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- rtl/adjustable_window_moving_average.sv -----
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: sample, command_byte; tuser: action
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: average, window_used
//
// a command word may move the window; a sample word sums the n newest history entries,
// n the window, into SUMW = SAMPLE_BITS + clog2(HISTORY_DEPTH + 1) bits, 20 by default,
// read from the history ram one entry per cycle, then divides the sum by n in the divider
// history lives in a circular ram; per-entry valid flops make unwritten entries read zero
// input is not ready while a sample is being worked; a stalled result holds the last step
// depends on awma_pkg, awma_ram, awma_alu and the macros header
`default_nettype none

module adjustable_window_moving_average #(
  parameter int HISTORY_DEPTH = awma_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = awma_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [15:0] sample, [23:16] command_byte
  input  wire logic        s_axis_tuser,   // [0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata    // [15:0] average, [19:16] window_used, rest zero
);

  import awma_pkg::*;

  `include "adjustable_window_moving_average_macros.svh"

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int NB   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUMW = SAMPLE_BITS + NB;
  localparam int DCW  = $clog2(SUMW + 1);

  localparam logic [NB-1:0]  WIN_MAX   = NB'(HISTORY_DEPTH);
  localparam logic [NB-1:0]  WIN_ONE   = NB'(1);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [NB:0]    DEPTH_EXT = (NB+1)'(HISTORY_DEPTH);
  localparam logic [DCW-1:0] DIV_LAST  = DCW'(SUMW - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [NB-1:0]            window_q, window_d;
  logic [AW-1:0]            newest_q, newest_d;
  logic [HISTORY_DEPTH-1:0] valid_q, valid_d;
  logic [NB-1:0]            cnt_q, cnt_d;
  logic                     pend_q, pend_d;
  logic                     vld_q, vld_d;
  logic [DCW-1:0]           dcnt_q, dcnt_d;
  logic                     out_vld_q, out_vld_d;
  logic [AVG_BITS-1:0]      avg_q, avg_d;
  logic [WIN_BITS-1:0]      win_out_q, win_out_d;

  logic                     s_acc;
  logic                     action;
  logic [7:0]               cmd;
  logic [SAMPLE_BITS-1:0]   sample_in;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic [NB:0]              newest_ext, cnt_ext, addr_wide;
  logic                     ram_we;
  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic [SAMPLE_BITS-1:0]   addend;
  logic [SUMW-1:0]          acc;
  logic [SUMW+15:0]         avg_full;
  logic [NB+3:0]            win_full;
  alu_ctrl_t                alu_ctrl;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign action        = s_axis_tuser;
  assign cmd           = s_axis_tdata[23:16];
  assign sample_in     = SAMPLE_BITS'(s_axis_tdata[15:0]);

  assign wr_addr = (newest_q == LAST_ADDR) ? '0 : newest_q + AW'(1);
  assign ram_we  = s_acc && !action;

  // k-th newest entry, wrapping below address zero
  assign newest_ext = (NB+1)'(newest_q);
  assign cnt_ext    = (NB+1)'(cnt_q);
  assign addr_wide  = (newest_ext >= cnt_ext) ? newest_ext - cnt_ext
                                              : newest_ext + DEPTH_EXT - cnt_ext;
  assign rd_addr    = addr_wide[AW-1:0];

  assign addend   = vld_q ? ram_rdata : '0;
  assign avg_full = (SUMW+16)'(acc);
  assign win_full = (NB+4)'(window_q);

  awma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (sample_in),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  awma_alu #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NB          (NB),
    .SUMW        (SUMW)
  ) u_alu (
    .clk_i     (clk_i),
    .ctrl_i    (alu_ctrl),
    .addend_i  (addend),
    .divisor_i (window_q),
    .acc_o     (acc)
  );

  always_comb begin
    state_d   = state_q;
    window_d  = window_q;
    newest_d  = newest_q;
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    vld_d     = vld_q;
    dcnt_d    = dcnt_q;
    out_vld_d = out_vld_q;
    avg_d     = avg_q;
    win_out_d = win_out_q;
    alu_ctrl  = '0;

    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (action) begin
            if (cmd == CMD_WIDEN && window_q < WIN_MAX) begin
              window_d = window_q + WIN_ONE;
            end else if (cmd == CMD_NARROW && window_q > WIN_ONE) begin
              window_d = window_q - WIN_ONE;
            end
          end else begin
            newest_d         = wr_addr;
            valid_d[wr_addr] = 1'b1;
            alu_ctrl.clear   = 1'b1;
            cnt_d            = '0;
            pend_d           = 1'b0;
            state_d          = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        // read issued this cycle is added the next
        if (pend_q) begin
          alu_ctrl.add = 1'b1;
        end
        if (cnt_q != window_q) begin
          cnt_d  = cnt_q + NB'(1);
          pend_d = 1'b1;
          vld_d  = valid_q[rd_addr];
        end else begin
          pend_d = 1'b0;
          if (pend_q) begin
            dcnt_d  = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        alu_ctrl.div_step = 1'b1;
        dcnt_d            = dcnt_q + DCW'(1);
        if (dcnt_q == DIV_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          avg_d     = avg_full[15:0];
          win_out_d = win_full[3:0];
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      window_q  <= WIN_ONE;
      newest_q  <= '0;
      valid_q   <= '0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      vld_q     <= 1'b0;
      dcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      window_q  <= window_d;
      newest_q  <= newest_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      vld_q     <= vld_d;
      dcnt_q    <= dcnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q     <= avg_d;
    win_out_q <= win_out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, win_out_q, avg_q};

  `AWMA_ASSERT_SAME(a_window_range, 1'b1,
                    (window_q >= WIN_ONE) && (window_q <= WIN_MAX),
                    "window out of range")
  `AWMA_ASSERT_NEXT(a_sample_keeps_window, s_acc && !action,
                    window_q == $past(window_q),
                    "sample changed window")
  `AWMA_ASSERT_SAME(a_sum_count, state_q == ST_SUM,
                    cnt_q <= window_q,
                    "sum read count past window")
  `AWMA_ASSERT_NEXT(a_done_holds, (state_q == ST_DONE) && out_vld_q && !m_axis_tready,
                    (state_q == ST_DONE) && $stable(avg_q),
                    "result overwritten while stalled")

endmodule

`default_nettype wire

// ----- bench/adjustable_window_moving_average_tb.sv -----
// testbench for adjustable_window_moving_average: directed and random sample and command words
// checked against a scoreboard that tracks the history line and the window length
// depends on awma_pkg and the block's rtl
module adjustable_window_moving_average_tb;
  import awma_pkg::*;

  localparam int          DEPTH         = HISTORY_DEPTH_DEF;
  localparam int unsigned RANDOM_WORDS  = 800;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned DRAIN_AT      = 500;
  localparam longint      RUN_LIMIT     = 64'd8_000_000;

  typedef enum bit {ACT_SAMPLE = 1'b0, ACT_COMMAND = 1'b1} action_e;
  typedef enum int unsigned {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PATTERN} sink_mode_e;

  typedef struct packed {
    logic [WIN_BITS-1:0] window_used;
    logic [AVG_BITS-1:0] average;
  } avg_result_t;

  class window_average_board;
    logic [SAMPLE_BITS_DEF-1:0] history [DEPTH];
    int unsigned window;
    int unsigned words_taken;
    int unsigned mismatches;
    avg_result_t averages_due [$];

    function new();
      foreach (history[i]) history[i] = '0;
      window      = 1;
      words_taken = 0;
      mismatches  = 0;
    endfunction

    // commands move the window, samples shift in and produce one average
    function void take_word(action_e act, logic [15:0] smp, logic [7:0] cmd);
      int unsigned sum;
      avg_result_t res;
      sum = 0;
      words_taken++;
      if (act == ACT_COMMAND) begin
        if (cmd == CMD_WIDEN && window < DEPTH) window++;
        else if (cmd == CMD_NARROW && window > 1) window--;
        return;
      end
      for (int i = DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = smp;
      for (int i = 0; i < window; i++) sum += history[i];
      res.average     = AVG_BITS'(sum / window);
      res.window_used = WIN_BITS'(window);
      averages_due.push_back(res);
    endfunction

    function void check_average(logic [23:0] word);
      avg_result_t want;
      if (averages_due.size() == 0) begin
        $error("unexpected result word 0x%06h", word);
        mismatches++;
        return;
      end
      want = averages_due.pop_front();
      if (word[AVG_BITS-1:0] !== want.average) begin
        $error("average: expected %0d, actual %0d", want.average, word[AVG_BITS-1:0]);
        mismatches++;
      end
      if (word[AVG_BITS +: WIN_BITS] !== want.window_used) begin
        $error("window_used: expected %0d, actual %0d", want.window_used,
               word[AVG_BITS +: WIN_BITS]);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return averages_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [15:0] sample, [23:16] command_byte
  logic        s_axis_tuser;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [15:0] average, [19:16] window_used

  window_average_board board = new();

  adjustable_window_moving_average uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic send_word(action_e act, logic [15:0] smp, logic [7:0] cmd);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {cmd, smp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.take_word(act, smp, cmd);
  endtask

  // idle input with junk on the bus
  task automatic pause_input(int unsigned cycles);
    if (cycles == 0) return;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 24'($urandom);
    s_axis_tuser  <= 1'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    pause_input(1);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 16'hFFFF;
    if (roll < 25) return 16'h0000;
    if (roll < 40) return 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    int unsigned counted;
    int unsigned burst;
    int unsigned roll;
    int unsigned widen_pct;
    bit          drained;
    action_e     act;
    logic [15:0] smp;
    logic [7:0]  cmd;

    counted   = 0;
    burst     = 0;
    widen_pct = 50;
    drained   = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale sample, then narrow at the lower bound
    send_word(ACT_SAMPLE, 16'hFFFF, 8'h00);
    send_word(ACT_COMMAND, 16'hFFFF, CMD_NARROW);
    send_word(ACT_SAMPLE, 16'h0000, 8'hFF);
    // widen past the upper bound
    repeat (10) send_word(ACT_COMMAND, 16'h0000, CMD_WIDEN);
    // reset zeros still inside the window pull the average down
    send_word(ACT_SAMPLE, 16'hFFFF, CMD_WIDEN);
    // bytes that are not commands
    send_word(ACT_COMMAND, 16'h0000, 8'h75);
    send_word(ACT_COMMAND, 16'hA5A5, 8'hFF);
    send_word(ACT_COMMAND, 16'h5A5A, 8'h00);
    send_word(ACT_SAMPLE, 16'h8001, CMD_NARROW);
    send_word(ACT_COMMAND, 16'h0000, CMD_NARROW);
    send_word(ACT_SAMPLE, 16'h0003, 8'h00);
    send_word(ACT_SAMPLE, 16'hFFFF, 8'h00);
    send_word(ACT_SAMPLE, 16'hFFFE, 8'hAA);

    while (counted < RANDOM_WORDS) begin
      if (burst == 0) begin
        pause_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        burst = $urandom_range(1, 24);
      end
      burst--;
      // lean the window walk one way or the other so both bounds get hit
      if (counted % 100 == 0) widen_pct = $urandom_range(10, 90);
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        act = ACT_SAMPLE;
        smp = pick_sample();
        cmd = 8'($urandom);
      end else if (roll < 96) begin
        act = ACT_COMMAND;
        smp = 16'($urandom);
        cmd = ($urandom_range(0, 99) < widen_pct) ? CMD_WIDEN : CMD_NARROW;
      end else begin
        act = ACT_COMMAND;
        smp = 16'($urandom);
        cmd = 8'($urandom);
      end
      send_word(act, smp, cmd);
      if (act == ACT_SAMPLE || cmd == CMD_WIDEN || cmd == CMD_NARROW) counted++;
      if (counted >= DRAIN_AT && !drained) begin
        drain_results();
        drained = 1'b1;
        burst   = 0;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned cycle_no;
    bit          held;
    bit          ready;

    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    cycle_no  = 0;
    held      = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cycle_no++;
      if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_average(m_axis_tdata);
      // one long hold-off so the block backs up and stalls its input
      if (!held && board.words_taken >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   ready = 1'b1;
          SINK_COIN:   ready = 1'($urandom_range(0, 1));
          SINK_SPARSE: ready = ($urandom_range(0, 3) == 0);
          default:     ready = (cycle_no % 5) != 0;
        endcase
        m_axis_tready <= rst_ni && ready;
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
